// ----- hw/rtl/brl_pkg.sv -----
// ----------------------------------------------------------------------------
// Bresenham line rasterizer package
// Shared types and constants for the line rasterizer front end, command
// queue and stepping engine.
// ----------------------------------------------------------------------------
package brl_pkg;

  // Coordinate width of every point on the raster.
  localparam int COORD_BITS = 10;
  // Error term width: deltas plus sign and headroom for the doubled term.
  localparam int ERR_BITS   = COORD_BITS + 3;
  // Entries in the queue between front end and stepping engine.
  localparam int QUEUE_DEPTH = 2;

  typedef logic [COORD_BITS-1:0]      coord_t;
  typedef logic signed [ERR_BITS-1:0] err_t;

  typedef enum logic {
    OP_LOAD    = 1'b0,
    OP_ADVANCE = 1'b1
  } opcode_e;

  // Input item as seen on the input channel.
  typedef struct packed {
    opcode_e opcode;
    coord_t  start_x;
    coord_t  start_y;
    coord_t  end_x;
    coord_t  end_y;
  } brl_in_t;

  // Result item as seen on the output channel.
  typedef struct packed {
    coord_t point_x;
    coord_t point_y;
    logic   point_valid;
    logic   last_point;
  } brl_out_t;

  // Classified command with the line setup already worked out.
  typedef struct packed {
    opcode_e opcode;
    coord_t  start_x;
    coord_t  start_y;
    coord_t  end_x;
    coord_t  end_y;
    coord_t  abs_dx;
    coord_t  abs_dy;
    logic    x_dir_neg;
    logic    y_dir_neg;
    logic    degenerate;
  } brl_cmd_t;

endpackage

// ----- hw/rtl/brl_front.sv -----
// ----------------------------------------------------------------------------
// Line rasterizer front end
// Accepts input items, classifies them and works out the line setup
// (absolute deltas, step directions, single-point lines) for loads.
// ----------------------------------------------------------------------------
module brl_front
  import brl_pkg::*;
(
  input  brl_in_t  in_data_i,
  output brl_cmd_t cmd_o
);

  logic x_neg, y_neg;

  // Step directions come from comparing the endpoints.
  assign x_neg = (in_data_i.end_x < in_data_i.start_x);
  assign y_neg = (in_data_i.end_y < in_data_i.start_y);

  // Build the classified command with absolute deltas.
  always_comb begin
    cmd_o.opcode     = in_data_i.opcode;
    cmd_o.start_x    = in_data_i.start_x;
    cmd_o.start_y    = in_data_i.start_y;
    cmd_o.end_x      = in_data_i.end_x;
    cmd_o.end_y      = in_data_i.end_y;
    cmd_o.x_dir_neg  = x_neg;
    cmd_o.y_dir_neg  = y_neg;
    cmd_o.abs_dx     = x_neg ? (in_data_i.start_x - in_data_i.end_x)
                             : (in_data_i.end_x - in_data_i.start_x);
    cmd_o.abs_dy     = y_neg ? (in_data_i.start_y - in_data_i.end_y)
                             : (in_data_i.end_y - in_data_i.start_y);
    cmd_o.degenerate = (in_data_i.start_x == in_data_i.end_x) &&
                       (in_data_i.start_y == in_data_i.end_y);
  end

endmodule

// ----- hw/rtl/brl_queue.sv -----
// ----------------------------------------------------------------------------
// Line rasterizer command queue
// Small first-in first-out buffer of classified commands that lets the
// front end and the stepping engine stall independently.
// ----------------------------------------------------------------------------
module brl_queue
  import brl_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     push_i,
  input  brl_cmd_t push_data_i,
  output logic     full_o,
  input  logic     pop_i,
  output logic     empty_o,
  output brl_cmd_t pop_data_o
);

  localparam int PtrBits = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CntBits = $clog2(QUEUE_DEPTH + 1);

  brl_cmd_t           mem_q [QUEUE_DEPTH];
  logic [PtrBits-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrBits-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntBits-1:0] count_q, count_d;

  assign full_o     = (count_q == CntBits'(QUEUE_DEPTH));
  assign empty_o    = (count_q == '0);
  assign pop_data_o = mem_q[rd_ptr_q];

  // Pointer and fill count updates.
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrBits'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrBits'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (!push_i && pop_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Entry storage needs no reset.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

// ----- hw/rtl/brl_back.sv -----
// ----------------------------------------------------------------------------
// Line rasterizer stepping engine
// Holds the line state, carries out load and advance commands one per
// cycle while its output register is free or draining, and registers the result.
// ----------------------------------------------------------------------------
module brl_back
  import brl_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     cmd_valid_i,
  input  brl_cmd_t cmd_i,
  output logic     cmd_pop_o,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output brl_out_t out_data_o
);

  localparam int PadBits = ERR_BITS - COORD_BITS;

  coord_t   cur_x_q, cur_x_d, cur_y_q, cur_y_d;
  coord_t   stop_x_q, stop_x_d, stop_y_q, stop_y_d;
  coord_t   abs_dx_q, abs_dx_d, abs_dy_q, abs_dy_d;
  err_t     err_q, err_d;
  logic     x_neg_q, x_neg_d, y_neg_q, y_neg_d;
  logic     active_q, active_d;
  logic     out_valid_q;
  brl_out_t out_q, out_d;

  logic signed [ERR_BITS:0] e2, adx_w, ady_w;
  err_t adx_e, ady_e;
  logic step_x, step_y;
  coord_t nx, ny;

  // A command is taken whenever the output register is free or draining.
  assign cmd_pop_o   = cmd_valid_i && (!out_valid_q || out_ready_i);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // Error term decisions for one step along the line.
  assign adx_e  = err_t'({{PadBits{1'b0}}, abs_dx_q});
  assign ady_e  = err_t'({{PadBits{1'b0}}, abs_dy_q});
  assign e2     = {err_q, 1'b0};
  assign adx_w  = $signed({{(PadBits + 1){1'b0}}, abs_dx_q});
  assign ady_w  = $signed({{(PadBits + 1){1'b0}}, abs_dy_q});
  assign step_x = (e2 >= -ady_w);
  assign step_y = (e2 <= adx_w);
  assign nx     = step_x ? (x_neg_q ? cur_x_q - 1'b1 : cur_x_q + 1'b1) : cur_x_q;
  assign ny     = step_y ? (y_neg_q ? cur_y_q - 1'b1 : cur_y_q + 1'b1) : cur_y_q;

  // Command execution.
  always_comb begin
    cur_x_d  = cur_x_q;
    cur_y_d  = cur_y_q;
    stop_x_d = stop_x_q;
    stop_y_d = stop_y_q;
    abs_dx_d = abs_dx_q;
    abs_dy_d = abs_dy_q;
    err_d    = err_q;
    x_neg_d  = x_neg_q;
    y_neg_d  = y_neg_q;
    active_d = active_q;
    out_d    = '0;
    case (cmd_i.opcode)
      OP_LOAD: begin
        cur_x_d  = cmd_i.start_x;
        cur_y_d  = cmd_i.start_y;
        stop_x_d = cmd_i.end_x;
        stop_y_d = cmd_i.end_y;
        abs_dx_d = cmd_i.abs_dx;
        abs_dy_d = cmd_i.abs_dy;
        x_neg_d  = cmd_i.x_dir_neg;
        y_neg_d  = cmd_i.y_dir_neg;
        err_d    = err_t'({{PadBits{1'b0}}, cmd_i.abs_dx})
                 - err_t'({{PadBits{1'b0}}, cmd_i.abs_dy});
        active_d = !cmd_i.degenerate;
        out_d.point_x     = cmd_i.start_x;
        out_d.point_y     = cmd_i.start_y;
        out_d.point_valid = 1'b1;
        out_d.last_point  = cmd_i.degenerate;
      end
      OP_ADVANCE: begin
        if (active_q) begin
          cur_x_d = nx;
          cur_y_d = ny;
          err_d   = err_q - (step_x ? ady_e : '0) + (step_y ? adx_e : '0);
          out_d.point_x     = nx;
          out_d.point_y     = ny;
          out_d.point_valid = 1'b1;
          out_d.last_point  = (nx == stop_x_q) && (ny == stop_y_q);
          active_d = !out_d.last_point;
        end
      end
      default: begin
        out_d = '0;
      end
    endcase
  end

  // Line state and output valid.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_x_q     <= '0;
      cur_y_q     <= '0;
      stop_x_q    <= '0;
      stop_y_q    <= '0;
      abs_dx_q    <= '0;
      abs_dy_q    <= '0;
      err_q       <= '0;
      x_neg_q     <= 1'b0;
      y_neg_q     <= 1'b0;
      active_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_pop_o) begin
        cur_x_q  <= cur_x_d;
        cur_y_q  <= cur_y_d;
        stop_x_q <= stop_x_d;
        stop_y_q <= stop_y_d;
        abs_dx_q <= abs_dx_d;
        abs_dy_q <= abs_dy_d;
        err_q    <= err_d;
        x_neg_q  <= x_neg_d;
        y_neg_q  <= y_neg_d;
        active_q <= active_d;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Result payload register.
  always_ff @(posedge clk_i) begin
    if (cmd_pop_o) begin
      out_q <= out_d;
    end
  end

endmodule

// ----- hw/rtl/bresenham_line_rasterizer.sv -----
// ----------------------------------------------------------------------------
// Bresenham line rasterizer
// All-octant integer line rasterizer with a decoupled front end, command
// queue and pixel stepping engine.
// ----------------------------------------------------------------------------
// Usage: the input channel (in_valid_i, in_ready_o, in_data_i) carries
// commands. A load command gives the two endpoints and returns the start
// point; each advance command returns the next pixel of the line, with
// last_point set on the line end. An advance with no line active returns
// a result with point_valid low and zero coordinates.
// The output channel (out_valid_o, out_ready_i, out_data_o) returns exactly
// one result for each command, in order.
// A command is written into the queue at the input transfer; the stepping
// engine takes it from the queue once its result register is free or
// draining and registers its result there, so the queue and the result
// register lie between the input transfer and the result transfer.
// Throughput is one command per cycle while the receiver takes results;
// a stalled result register holds the stepping engine.
// After reset no line is active and the queue is empty. When the receiver
// stalls, the result register holds, the queue fills (two entries) and
// in_ready_o then drops until the receiver takes results again.
// ----------------------------------------------------------------------------
module bresenham_line_rasterizer
  import brl_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  brl_in_t  in_data_i,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output brl_out_t out_data_o
);

  brl_cmd_t front_cmd, queue_cmd;
  logic     queue_full, queue_empty, queue_pop;

  assign in_ready_o = !queue_full;

  // Classify incoming commands and set up the line.
  brl_front u_front (
    .in_data_i (in_data_i),
    .cmd_o     (front_cmd)
  );

  // Buffer classified commands between front end and stepping engine.
  brl_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (in_valid_i && !queue_full),
    .push_data_i (front_cmd),
    .full_o      (queue_full),
    .pop_i       (queue_pop),
    .empty_o     (queue_empty),
    .pop_data_o  (queue_cmd)
  );

  // Step along the line and drive the results.
  brl_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (!queue_empty),
    .cmd_i       (queue_cmd),
    .cmd_pop_o   (queue_pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

// ----- tb/sv/brl_line_checker.sv -----
// ----------------------------------------------------------------------------
// Bresenham line rasterizer pixel checker
// Watches both channels of the rasterizer, traces each accepted command
// through its own copy of the line state and compares every returned pixel,
// field by field, with the oldest traced pixel still waiting.
// ----------------------------------------------------------------------------
module brl_line_checker
  import brl_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_ready_o,
  input  brl_in_t     in_data_i,
  input  logic        out_valid_o,
  input  logic        out_ready_i,
  input  brl_out_t    out_data_o,
  input  logic        end_check_i,
  output int unsigned pending_o,
  output int unsigned mismatch_count_o
);

  timeunit 1ns;
  timeprecision 1ps;

  // Traced line state.
  coord_t cur_x  = '0;
  coord_t cur_y  = '0;
  coord_t stop_x = '0;
  coord_t stop_y = '0;
  coord_t abs_dx = '0;
  coord_t abs_dy = '0;
  err_t   err_acc = '0;
  logic   x_neg   = 1'b0;
  logic   y_neg   = 1'b0;
  logic   drawing = 1'b0;

  brl_out_t    expected_pixels[$];
  int unsigned mismatches = 0;
  logic        end_seen   = 1'b0;

  initial begin
    pending_o        = 0;
    mismatch_count_o = 0;
  end

  // Print one line for a mismatch and count it.
  task automatic report_mismatch(input string msg);
    mismatches++;
    $display("[%0t] MISMATCH: %s", $time, msg);
  endtask

  // Work out the pixel that one command returns and update the line state.
  function automatic brl_out_t trace_pixel(input brl_in_t cmd);
    brl_out_t px;
    int       e2;
    px = '0;
    if (cmd.opcode == OP_LOAD) begin
      cur_x   = cmd.start_x;
      cur_y   = cmd.start_y;
      stop_x  = cmd.end_x;
      stop_y  = cmd.end_y;
      x_neg   = cmd.end_x < cmd.start_x;
      y_neg   = cmd.end_y < cmd.start_y;
      abs_dx  = x_neg ? cmd.start_x - cmd.end_x : cmd.end_x - cmd.start_x;
      abs_dy  = y_neg ? cmd.start_y - cmd.end_y : cmd.end_y - cmd.start_y;
      err_acc = err_t'(int'(abs_dx) - int'(abs_dy));
      px.point_x     = cur_x;
      px.point_y     = cur_y;
      px.point_valid = 1'b1;
      px.last_point  = (cmd.start_x == cmd.end_x) && (cmd.start_y == cmd.end_y);
      drawing        = !px.last_point;
    end else if (drawing) begin
      // Both tests use the doubled error from before this step.
      e2 = 2 * int'(err_acc);
      if (e2 >= -int'(abs_dy)) begin
        err_acc = err_t'(int'(err_acc) - int'(abs_dy));
        cur_x   = x_neg ? cur_x - 1'b1 : cur_x + 1'b1;
      end
      if (e2 <= int'(abs_dx)) begin
        err_acc = err_t'(int'(err_acc) + int'(abs_dx));
        cur_y   = y_neg ? cur_y - 1'b1 : cur_y + 1'b1;
      end
      px.point_x     = cur_x;
      px.point_y     = cur_y;
      px.point_valid = 1'b1;
      px.last_point  = (cur_x == stop_x) && (cur_y == stop_y);
      if (px.last_point) begin
        drawing = 1'b0;
      end
    end
    return px;
  endfunction

  // Compare returned pixels first, then trace the command taken at this edge.
  always @(posedge clk_i or negedge rst_ni) begin
    brl_out_t want;
    if (!rst_ni) begin
      cur_x   = '0;
      cur_y   = '0;
      stop_x  = '0;
      stop_y  = '0;
      abs_dx  = '0;
      abs_dy  = '0;
      err_acc = '0;
      x_neg   = 1'b0;
      y_neg   = 1'b0;
      drawing = 1'b0;
      expected_pixels.delete();
    end else begin
      if (out_valid_o && out_ready_i) begin
        if (expected_pixels.size() == 0) begin
          report_mismatch($sformatf("result transfer with nothing expected: %p",
                                    out_data_o));
        end else begin
          want = expected_pixels.pop_front();
          if (out_data_o.point_x !== want.point_x) begin
            report_mismatch($sformatf("point_x got %0d want %0d",
                                      out_data_o.point_x, want.point_x));
          end
          if (out_data_o.point_y !== want.point_y) begin
            report_mismatch($sformatf("point_y got %0d want %0d",
                                      out_data_o.point_y, want.point_y));
          end
          if (out_data_o.point_valid !== want.point_valid) begin
            report_mismatch($sformatf("point_valid got %b want %b",
                                      out_data_o.point_valid, want.point_valid));
          end
          if (out_data_o.last_point !== want.last_point) begin
            report_mismatch($sformatf("last_point got %b want %b",
                                      out_data_o.last_point, want.last_point));
          end
        end
      end
      if (in_valid_i && in_ready_o) begin
        expected_pixels.push_back(trace_pixel(in_data_i));
      end
      // Anything still waiting when the run closes never arrived.
      if (end_check_i && !end_seen) begin
        end_seen = 1'b1;
        if (expected_pixels.size() != 0) begin
          report_mismatch($sformatf("%0d expected results never arrived",
                                    expected_pixels.size()));
        end
      end
    end
    pending_o        <= expected_pixels.size();
    mismatch_count_o <= mismatches;
  end

endmodule

// ----- tb/sv/tb.sv -----
// ----------------------------------------------------------------------------
// Bresenham line rasterizer testbench
// Drives directed and random line commands into the rasterizer with random
// gaps on the input side and random stalls on the result side, and leaves
// all checking to the pixel checker beside the block.
// ----------------------------------------------------------------------------
module tb
  import brl_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned RandomItems = 1250;
  localparam int unsigned IdlePercent = 35;
  localparam int unsigned CoordMax    = (1 << COORD_BITS) - 1;
  localparam int          InBits      = $bits(brl_in_t);

  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        in_valid_i  = 1'b0;
  logic        in_ready_o;
  brl_in_t     in_data_i   = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  brl_out_t    out_data_o;
  logic        end_check   = 1'b0;
  int unsigned pending;
  int unsigned mismatch_count;

  // Counts transfers on the input channel; also marks the stretch with no
  // idling on either side.
  int unsigned sent  = 0;
  logic        quiet = 1'b0;

  bresenham_line_rasterizer DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

  brl_line_checker u_checker (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .in_data_i       (in_data_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .out_data_o      (out_data_o),
    .end_check_i     (end_check),
    .pending_o       (pending),
    .mismatch_count_o(mismatch_count)
  );

  // Clock with a 12 ns period.
  always #6 clk_i = ~clk_i;

  // Run limit well beyond the slowest correct run.
  initial begin
    #5_000_000;
    $display("FAILURE");
    $finish;
  end

  // Result side stalls at random outside the quiet stretch.
  always @(posedge clk_i) begin
    out_ready_i <= quiet || ($urandom_range(99) >= IdlePercent);
  end

  // Clamp a coordinate onto the raster.
  function automatic coord_t clip(input int v);
    if (v < 0) return '0;
    if (v > int'(CoordMax)) return coord_t'(CoordMax);
    return coord_t'(v);
  endfunction

  // Offer one command after a random gap and hold it until the transfer.
  task automatic send_cmd(input brl_in_t cmd);
    while (!quiet && $urandom_range(99) < IdlePercent) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= cmd;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    sent++;
    quiet = (sent >= 500) && (sent < 750);
  endtask

  task automatic send_load(input coord_t x0, input coord_t y0,
                           input coord_t x1, input coord_t y1);
    brl_in_t cmd;
    cmd.opcode  = OP_LOAD;
    cmd.start_x = x0;
    cmd.start_y = y0;
    cmd.end_x   = x1;
    cmd.end_y   = y1;
    send_cmd(cmd);
  endtask

  // Advance with random content in the fields it ignores.
  task automatic send_advance(input int unsigned count);
    brl_in_t cmd;
    repeat (count) begin
      cmd         = brl_in_t'(InBits'({$urandom, $urandom}));
      cmd.opcode  = OP_ADVANCE;
      send_cmd(cmd);
    end
  endtask

  // Stimulus, then drain and verdict.
  initial begin
    int unsigned pick;
    int          x0, y0, x1, y1, span, steps;
    brl_in_t     noise;

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // Advance before any line, then a degenerate line and an advance after it.
    send_advance(1);
    send_load(10'd5, 10'd5, 10'd5, 10'd5);
    send_advance(1);
    // Full-raster diagonals; each load drops the line still in progress.
    send_load('0, '0, coord_t'(CoordMax), coord_t'(CoordMax));
    send_advance(2);
    send_load(coord_t'(CoordMax), coord_t'(CoordMax), '0, '0);
    send_advance(2);
    send_load(coord_t'(CoordMax), '0, '0, coord_t'(CoordMax));
    send_advance(1);
    send_load('0, coord_t'(CoordMax), coord_t'(CoordMax), '0);
    send_advance(1);
    // Degenerate line at the far corner.
    send_load(coord_t'(CoordMax), coord_t'(CoordMax),
              coord_t'(CoordMax), coord_t'(CoordMax));
    // Steep line towards smaller values, walked to its end and one past it.
    send_load(10'd10, 10'd20, 10'd9, 10'd14);
    send_advance(7);

    // Random part: mostly short lines walked to their end.
    while (sent < RandomItems) begin
      pick = $urandom_range(99);
      if (pick < 80) begin
        span = ($urandom_range(9) == 0) ? 60 : 15;
        x0 = $urandom_range(CoordMax);
        y0 = $urandom_range(CoordMax);
        x1 = int'(clip(x0 + int'($urandom_range(2 * span)) - span));
        y1 = int'(clip(y0 + int'($urandom_range(2 * span)) - span));
        steps = (x1 > x0) ? x1 - x0 : x0 - x1;
        if (((y1 > y0) ? y1 - y0 : y0 - y1) > steps) begin
          steps = (y1 > y0) ? y1 - y0 : y0 - y1;
        end
        pick = $urandom_range(9);
        if (pick == 0) begin
          steps = steps + int'($urandom_range(1, 3));
        end else if (pick == 1 && steps > 0) begin
          steps = $urandom_range(steps - 1);
        end
        send_load(coord_t'(x0), coord_t'(y0), coord_t'(x1), coord_t'(y1));
        send_advance(steps);
      end else if (pick < 90) begin
        // Long line anywhere on the raster, cut short.
        send_load(coord_t'($urandom), coord_t'($urandom),
                  coord_t'($urandom), coord_t'($urandom));
        send_advance($urandom_range(2, 10));
      end else begin
        noise = brl_in_t'(InBits'({$urandom, $urandom}));
        send_cmd(noise);
      end
    end
    in_valid_i <= 1'b0;

    // Wait for every result, then for the pipeline latency.
    do @(posedge clk_i); while (pending != 0);
    repeat (4) @(posedge clk_i);
    end_check <= 1'b1;
    repeat (2) @(posedge clk_i);

    if (mismatch_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
